@@ src/skt_pkg.sv @@
// shared types and constants for the sorted key table
package skt_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned BlkW = $clog2(TableDepth + 1);
  localparam int unsigned KeyW = 31;
  localparam int unsigned CfgW = 9;
  localparam int unsigned CmpW = (BlkW > CfgW) ? BlkW : CfgW;

  typedef enum logic [1:0] {
    REQ_SEARCH = 2'd0,
    REQ_REGISTER = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_SEARCH_ALT = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_RESIDENT = 3'd0,
    ST_REGISTERED = 3'd1,
    ST_NOT_PRESENT = 3'd2,
    ST_FULL = 3'd3,
    ST_DELETED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CMP,
    CMD_SCAN,
    CMD_INS,
    CMD_DEL
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic [KeyW-1:0] key;
    logic [BlkW-1:0] count;
    logic [BlkW-1:0] blk;
  } bcast_t;

endpackage

@@ src/sorted_key_table_with_block_allocator_unit.sv @@
// top level of the sorted key table with block allocator
//
// requests enter on in_valid_i / in_stall_o with a request type and a key;
// search, search-or-register and delete each give one result on
// out_valid_o / out_stall_i with status, block number and entry count.
// the table is a row of cells, one per slot, each also owning the used bit
// of one block number. a request passes a compare step in all cells, then
// a scan step in which the hit block and the lowest free block ripple
// one cell per cycle to the end of the row, then an update step in which
// every cell not holding a smaller key shifts in from its neighbor on
// insert or delete, and the result is registered. the next request is
// accepted in the cycle after the result is taken.
// in_stall_o is high from acceptance until the result has been taken.
// a stalled result holds until out_stall_i falls.
// the max_blocks register is written on cfg_valid_i / cfg_ready_o; the user
// must write it only while idle, as the unit itself does not enforce this.
// reset empties the table, frees all blocks and sets max_blocks to 256.
module sorted_key_table_with_block_allocator_unit import skt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      req_type_i,
  input  logic [KeyW-1:0] key_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      status_o,
  output logic [BlkW-1:0] block_no_o,
  output logic [BlkW-1:0] entry_count_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_SCAN,
    S_UPD,
    S_OUT
  } state_e;

  state_e          state_q;
  logic [IdxW-1:0] scan_q;
  logic [1:0]      req_q;
  logic [KeyW-1:0] key_q;
  logic [BlkW-1:0] count_q;
  logic [CfgW-1:0] max_q;
  logic [2:0]      status_q;
  logic [BlkW-1:0] blk_q;

  bcast_t          bc;
  cmd_e            upd_cmd;
  status_e         upd_status;
  logic [BlkW-1:0] upd_blk;
  logic [BlkW-1:0] upd_count;

  logic [KeyW-1:0] key_w [TableDepth];
  logic [BlkW-1:0] blk_w [TableDepth];
  logic            lt_w  [TableDepth];
  logic [BlkW-1:0] hc_w  [TableDepth];
  logic [BlkW-1:0] fc_w  [TableDepth];

  logic [BlkW-1:0] hit_blk;
  logic [BlkW-1:0] free_blk;

  assign hit_blk  = hc_w[TableDepth-1];
  assign free_blk = fc_w[TableDepth-1];

  always_comb begin
    upd_status = ST_NOT_PRESENT;
    upd_blk    = '0;
    upd_count  = count_q;
    upd_cmd    = CMD_NONE;
    bc.key     = key_q;
    bc.count   = count_q;
    bc.blk     = '0;
    if (req_q == REQ_DELETE) begin
      if (hit_blk != '0) begin
        upd_status = ST_DELETED;
        upd_blk    = hit_blk;
        upd_count  = count_q - BlkW'(1);
        bc.blk     = hit_blk;
        upd_cmd    = CMD_DEL;
      end
    end else if (hit_blk != '0) begin
      upd_status = ST_RESIDENT;
      upd_blk    = hit_blk;
    end else if (req_q == REQ_REGISTER) begin
      if (free_blk == '0 || CmpW'(free_blk) > CmpW'(max_q)
          || count_q == BlkW'(TableDepth)) begin
        upd_status = ST_FULL;
      end else begin
        upd_status = ST_REGISTERED;
        upd_blk    = free_blk;
        upd_count  = count_q + BlkW'(1);
        bc.blk     = free_blk;
        upd_cmd    = CMD_INS;
      end
    end
    unique case (state_q)
      S_CMP:   bc.cmd = CMD_CMP;
      S_SCAN:  bc.cmd = CMD_SCAN;
      S_UPD:   bc.cmd = upd_cmd;
      default: bc.cmd = CMD_NONE;
    endcase
  end

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    logic [KeyW-1:0] lk;
    logic [BlkW-1:0] lb;
    logic            ll;
    logic [BlkW-1:0] lh;
    logic [BlkW-1:0] lf;
    logic [KeyW-1:0] rk;
    logic [BlkW-1:0] rb;
    if (i == 0) begin : g_first
      assign lk = '0;
      assign lb = '0;
      assign ll = 1'b1;
      assign lh = '0;
      assign lf = '0;
    end else begin : g_mid
      assign lk = key_w[i-1];
      assign lb = blk_w[i-1];
      assign ll = lt_w[i-1];
      assign lh = hc_w[i-1];
      assign lf = fc_w[i-1];
    end
    if (i == TableDepth - 1) begin : g_last
      assign rk = key_w[i];
      assign rb = blk_w[i];
    end else begin : g_inner
      assign rk = key_w[i+1];
      assign rb = blk_w[i+1];
    end
    skt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (IdxW'(i)),
      .bc_i        (bc),
      .left_key_i  (lk),
      .left_blk_i  (lb),
      .left_lt_i   (ll),
      .left_hc_i   (lh),
      .left_fc_i   (lf),
      .right_key_i (rk),
      .right_blk_i (rb),
      .key_o       (key_w[i]),
      .blk_o       (blk_w[i]),
      .lt_o        (lt_w[i]),
      .hc_o        (hc_w[i]),
      .fc_o        (fc_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      scan_q   <= '0;
      req_q    <= '0;
      key_q    <= '0;
      count_q  <= '0;
      max_q    <= CfgW'(256);
      status_q <= '0;
      blk_q    <= '0;
    end else begin
      if (cfg_valid_i) max_q <= cfg_data_i;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= req_type_i;
            key_q   <= key_i;
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          scan_q  <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          scan_q <= scan_q + IdxW'(1);
          if (scan_q == IdxW'(TableDepth - 2)) state_q <= S_UPD;
        end
        S_UPD: begin
          status_q <= upd_status;
          blk_q    <= upd_blk;
          count_q  <= upd_count;
          state_q  <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign status_o      = status_q;
  assign block_no_o    = blk_q;
  assign entry_count_o = count_q;
  assign cfg_ready_o   = 1'b1;

endmodule

@@ src/skt_cell.sv @@
// one table slot plus one block used bit, with scan carries
module skt_cell import skt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IdxW-1:0] idx_i,
  input  bcast_t          bc_i,
  input  logic [KeyW-1:0] left_key_i,
  input  logic [BlkW-1:0] left_blk_i,
  input  logic            left_lt_i,
  input  logic [BlkW-1:0] left_hc_i,
  input  logic [BlkW-1:0] left_fc_i,
  input  logic [KeyW-1:0] right_key_i,
  input  logic [BlkW-1:0] right_blk_i,
  output logic [KeyW-1:0] key_o,
  output logic [BlkW-1:0] blk_o,
  output logic            lt_o,
  output logic [BlkW-1:0] hc_o,
  output logic [BlkW-1:0] fc_o
);

  logic [KeyW-1:0] key_q, key_d;
  logic [BlkW-1:0] blk_q, blk_d;
  logic [BlkW-1:0] hc_q, hc_d;
  logic [BlkW-1:0] fc_q, fc_d;
  logic            lt_q, lt_d;
  logic            used_q, used_d;
  logic            occ;
  logic [BlkW-1:0] own_blk;

  assign occ     = BlkW'(idx_i) < bc_i.count;
  assign own_blk = BlkW'(idx_i) + BlkW'(1);

  always_comb begin
    key_d  = key_q;
    blk_d  = blk_q;
    hc_d   = hc_q;
    fc_d   = fc_q;
    lt_d   = lt_q;
    used_d = used_q;
    unique case (bc_i.cmd)
      CMD_CMP: begin
        lt_d = occ && (key_q < bc_i.key);
        hc_d = (occ && (key_q == bc_i.key)) ? blk_q : '0;
        fc_d = used_q ? '0 : own_blk;
      end
      CMD_SCAN: begin
        if (left_hc_i != '0) hc_d = left_hc_i;
        if (left_fc_i != '0) fc_d = left_fc_i;
      end
      CMD_INS: begin
        if (!lt_q) begin
          if (left_lt_i) begin
            key_d = bc_i.key;
            blk_d = bc_i.blk;
          end else begin
            key_d = left_key_i;
            blk_d = left_blk_i;
          end
        end
        if (bc_i.blk == own_blk) used_d = 1'b1;
      end
      CMD_DEL: begin
        if (!lt_q) begin
          key_d = right_key_i;
          blk_d = right_blk_i;
        end
        if (bc_i.blk == own_blk) used_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      lt_q   <= 1'b0;
    end else begin
      used_q <= used_d;
      lt_q   <= lt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    blk_q <= blk_d;
    hc_q  <= hc_d;
    fc_q  <= fc_d;
  end

  assign key_o = key_q;
  assign blk_o = blk_q;
  assign lt_o  = lt_q;
  assign hc_o  = hc_q;
  assign fc_o  = fc_q;

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the sorted key table with block allocator
`timescale 1ns / 1ps

module testbench;
  import skt_pkg::*;

  typedef struct {
    logic [1:0] req;
    logic [KeyW-1:0] key;
    logic is_cfg;
    logic [CfgW-1:0] cfg;
  } item_t;

  typedef struct {
    logic [2:0] status;
    logic [BlkW-1:0] blk;
    logic [BlkW-1:0] cnt;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = '0;
  logic [KeyW-1:0] key_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [BlkW-1:0] block_no_o;
  logic [BlkW-1:0] entry_count_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgW-1:0] cfg_data_i = '0;

  sorted_key_table_with_block_allocator_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .key_i,
    .out_valid_o, .out_stall_i, .status_o, .block_no_o, .entry_count_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // predictor state
  logic [KeyW-1:0] tbl_key [TableDepth];
  logic [BlkW-1:0] tbl_blk [TableDepth];
  bit used_map [TableDepth];
  int unsigned n_keys;
  int unsigned max_blk;

  item_t pending_q[$];
  result_t expected_q[$];
  logic [KeyW-1:0] live_keys[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0;
  int in_gap = 0;
  int out_gap = 0;
  item_t cur;
  bit cur_ok = 0;
  bit in_took = 0;
  bit cfg_took = 0;

  function automatic result_t predict_lookup(logic [1:0] rq, logic [KeyW-1:0] k);
    result_t r;
    int unsigned lo, hi, mid, nb, i;
    bit hit;
    lo = 0; hi = n_keys;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_key[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < n_keys) && (tbl_key[lo] == k);
    r.blk = '0;
    if (rq == REQ_DELETE) begin
      if (!hit) r.status = ST_NOT_PRESENT;
      else begin
        r.blk = tbl_blk[lo];
        if (r.blk >= 1 && r.blk <= TableDepth) used_map[r.blk - 1] = 0;
        for (i = lo; i + 1 < n_keys; i++) begin
          tbl_key[i] = tbl_key[i + 1];
          tbl_blk[i] = tbl_blk[i + 1];
        end
        n_keys--;
        r.status = ST_DELETED;
      end
    end else if (hit) begin
      r.status = ST_RESIDENT;
      r.blk = tbl_blk[lo];
    end else if (rq != REQ_REGISTER) begin
      r.status = ST_NOT_PRESENT;
    end else begin
      nb = 0;
      for (i = 0; i < TableDepth; i++)
        if (!used_map[i]) begin
          nb = (i + 1 > max_blk) ? 0 : i + 1;
          break;
        end
      if (nb == 0 || n_keys >= TableDepth) r.status = ST_FULL;
      else begin
        used_map[nb - 1] = 1;
        for (i = n_keys; i > lo; i--) begin
          tbl_key[i] = tbl_key[i - 1];
          tbl_blk[i] = tbl_blk[i - 1];
        end
        tbl_key[lo] = k;
        tbl_blk[lo] = BlkW'(nb);
        n_keys++;
        r.blk = BlkW'(nb);
        r.status = ST_REGISTERED;
      end
    end
    r.cnt = BlkW'(n_keys);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    int c;
    c = $urandom_range(0, 9);
    if (c < 6 && live_keys.size() > 0) return live_keys[$urandom_range(0, live_keys.size() - 1)];
    if (c == 6) return {KeyW{1'b1}};
    if (c == 7) return '0;
    return KeyW'($urandom());
  endfunction

  task automatic push_req(logic [1:0] rq, logic [KeyW-1:0] k);
    item_t it;
    it.req = rq; it.key = k; it.is_cfg = 0; it.cfg = '0;
    pending_q.push_back(it);
    if (rq == REQ_REGISTER && live_keys.size() < 64) live_keys.push_back(k);
  endtask

  task automatic push_cfg(logic [CfgW-1:0] v);
    item_t it;
    it.req = '0; it.key = '0; it.is_cfg = 1; it.cfg = v;
    pending_q.push_back(it);
  endtask

  initial forever #1 clk_i = ~clk_i;

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cur_ok && !cur.is_cfg && in_took) cur_ok = 0;
      if (cur_ok && cur.is_cfg && cfg_took) cur_ok = 0;
      if (!cur_ok && pending_q.size() > 0) begin
        if (pending_q[0].is_cfg) begin
          if (expected_q.size() == 0 && !out_valid_o && !in_stall_o) begin
            cur = pending_q.pop_front();
            cur_ok = 1;
            max_blk = cur.cfg;
          end
        end else if (in_gap > 0) in_gap--;
        else if (!calm && $urandom_range(0, 15) == 0) in_gap = $urandom_range(0, 12);
        else begin
          cur = pending_q.pop_front();
          cur_ok = 1;
          expected_q.push_back(predict_lookup(cur.req, cur.key));
        end
      end
      in_valid_i <= cur_ok && !cur.is_cfg;
      cfg_valid_i <= cur_ok && cur.is_cfg;
      if (cur_ok) begin
        req_type_i <= cur.req;
        key_i <= cur.key;
        cfg_data_i <= cur.cfg;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 12);
        out_stall_i <= 1'b1;
      end else out_stall_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles++;
    in_took = in_valid_i && !in_stall_o;
    cfg_took = cfg_valid_i && cfg_ready_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) report_mismatch("unexpected result", status_o, -1);
      else begin
        result_t e;
        e = expected_q.pop_front();
        if (status_o !== e.status) report_mismatch("status", status_o, e.status);
        if (block_no_o !== e.blk) report_mismatch("block_no", block_no_o, e.blk);
        if (entry_count_o !== e.cnt) report_mismatch("entry_count", entry_count_o, e.cnt);
      end
    end
    if (cycles > 2000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int i, ph;
    n_keys = 0; max_blk = 256;
    for (i = 0; i < TableDepth; i++) used_map[i] = 0;
    // directed requests
    push_req(REQ_SEARCH, '0);
    push_req(REQ_DELETE, '0);
    push_req(REQ_REGISTER, {KeyW{1'b1}});
    push_req(REQ_REGISTER, '0);
    push_req(REQ_REGISTER, 31'h2aaa_aaaa);
    push_req(REQ_REGISTER, 31'h5555_5555);
    push_req(REQ_REGISTER, '0);
    push_req(REQ_SEARCH, {KeyW{1'b1}});
    push_req(REQ_SEARCH_ALT, 31'h2aaa_aaaa);
    push_req(REQ_SEARCH_ALT, 31'h1234);
    push_req(REQ_DELETE, '0);
    push_req(REQ_DELETE, 31'h1234);
    push_req(REQ_REGISTER, 31'h77);
    push_cfg(9'd2);
    push_req(REQ_REGISTER, 31'h99);
    push_req(REQ_DELETE, 31'h2aaa_aaaa);
    push_req(REQ_REGISTER, 31'h99);
    push_cfg(9'd0);
    push_req(REQ_REGISTER, 31'h100);
    push_cfg(9'h1ff);
    push_req(REQ_REGISTER, 31'h100);
    push_cfg(9'd256);
    // random phases
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        1: push_cfg(9'd1);
        2: push_cfg(CfgW'($urandom_range(3, 40)));
        3: push_cfg(9'h1ff);
        4: push_cfg(9'd0);
        5: push_cfg(CfgW'($urandom_range(1, 511)));
        6: push_cfg(9'd256);
        default: ;
      endcase
      for (i = 0; i < 100; i++) begin
        int c;
        c = $urandom_range(0, 9);
        if (c < 5) push_req(REQ_REGISTER, (c < 3) ? KeyW'($urandom()) : pick_key());
        else if (c < 7) push_req(REQ_DELETE, pick_key());
        else push_req(2'($urandom_range(0, 3)), pick_key());
      end
    end
    #22 rst_ni = 1'b1;
    wait (pending_q.size() < 150);
    calm = 1;
    wait (pending_q.size() == 0 && !cur_ok && expected_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
